>>> rtl/dblms_pkg.sv
// shared types and constants for the led matrix scanner
package dblms_pkg;

  typedef enum logic [2:0] {
    OP_TICK    = 3'd0,
    OP_DRAW    = 3'd1,
    OP_STORE   = 3'd2,
    OP_CLEAR   = 3'd3,
    OP_REFRESH = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COPY,
    S_READ,
    S_EMIT
  } scan_state_t;

  localparam logic [2:0]  RED_BIT          = 3'h1;
  localparam logic [2:0]  GREEN_BIT        = 3'h2;
  localparam logic [2:0]  BLUE_BIT         = 3'h4;
  localparam logic [15:0] ROW_PERIOD_RESET = 16'd6;

endpackage

>>> rtl/double_buffered_led_matrix_scanner_core.sv
// Double-buffered RGB LED matrix row scanner. Both frames share one row-wide
// RAM (2*ROWS words of COLUMNS 3-bit pixels, one write and one registered read
// per cycle), with a flip-flop valid bit per row: a row that is not valid reads
// as black, so reset and clear-back-buffer take effect at once. Draw, store,
// clear, refresh and a tick that does not scan are done in the idle state. A
// tick that scans goes through the RAM read of the front row, then the output
// register load, which waits while an earlier word is still not taken. When a
// swap with copy takes effect, a row-by-row RAM copy runs in front of the scan
// read.
module double_buffered_led_matrix_scanner_core
  import dblms_pkg::*;
#(
  parameter int COLUMNS = 8,
  parameter int ROWS    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [7:0]  in_pixel_color,
  input  logic        in_copy_on_swap,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_row_index,
  output logic [7:0]  out_red_columns,
  output logic [7:0]  out_green_columns,
  output logic [7:0]  out_blue_columns
);

  localparam int CW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW     = $clog2(ROWS);
  localparam int DEPTH  = 2 * ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(ROWS + 1);

  typedef logic [COLUMNS-1:0][2:0] row_word_t;

  function automatic logic [ADDR_W-1:0] row_addr(input logic plane, input logic [RW-1:0] row);
    row_addr = ADDR_W'(row) + (plane ? ADDR_W'(ROWS) : ADDR_W'(0));
  endfunction

  // frame memory and per-row valid bits
  row_word_t          frame_mem [DEPTH];
  logic [DEPTH-1:0]   row_valid_r;
  row_word_t          rd_data_r;
  logic               rd_ok_r;

  scan_state_t        state_r, state_nxt;
  logic [15:0]        row_period_r, row_period_nxt;
  logic [15:0]        countdown_r, countdown_nxt;
  logic [RW-1:0]      scan_row_r, scan_row_nxt;
  logic [RW-1:0]      emit_row_r, emit_row_nxt;
  logic               back_select_r, back_select_nxt;
  logic               swap_pending_r, swap_pending_nxt;
  logic               copy_pending_r, copy_pending_nxt;
  logic [CNT_W-1:0]   cp_cnt_r, cp_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [3:0]         out_row_r, out_row_nxt;
  logic [7:0]         out_red_r, out_red_nxt;
  logic [7:0]         out_green_r, out_green_nxt;
  logic [7:0]         out_blue_r, out_blue_nxt;

  logic               mem_we;
  logic [ADDR_W-1:0]  waddr;
  logic [COLUMNS-1:0] wmask;
  row_word_t          wdata;
  logic               valid_val;
  logic               clear_back;
  logic               rd_en;
  logic [ADDR_W-1:0]  rd_addr;

  logic               in_bounds;
  logic [CW-1:0]      px_col;
  logic [RW-1:0]      px_row;
  logic [15:0]        cd_dec;
  logic [CNT_W-1:0]   cp_prev;
  logic [2:0]         pix;

  assign px_col    = in_pos_x[CW-1:0];
  assign px_row    = in_pos_y[RW-1:0];
  assign in_bounds = !in_pos_x[15] && (in_pos_x < 16'(COLUMNS)) &&
                     !in_pos_y[15] && (in_pos_y < 16'(ROWS));
  assign cd_dec    = (countdown_r == 16'd0) ? 16'd0 : countdown_r - 16'd1;
  assign cp_prev   = cp_cnt_r - CNT_W'(1);

  always_comb begin
    state_nxt        = state_r;
    row_period_nxt   = row_period_r;
    countdown_nxt    = countdown_r;
    scan_row_nxt     = scan_row_r;
    emit_row_nxt     = emit_row_r;
    back_select_nxt  = back_select_r;
    swap_pending_nxt = swap_pending_r;
    copy_pending_nxt = copy_pending_r;
    cp_cnt_nxt       = cp_cnt_r;
    out_valid_nxt    = out_valid_r;
    out_row_nxt      = out_row_r;
    out_red_nxt      = out_red_r;
    out_green_nxt    = out_green_r;
    out_blue_nxt     = out_blue_r;
    in_ready         = (state_r == S_IDLE);
    mem_we           = 1'b0;
    waddr            = row_addr(back_select_r, px_row);
    wmask            = '0;
    wdata            = '0;
    valid_val        = 1'b1;
    clear_back       = 1'b0;
    rd_en            = 1'b0;
    rd_addr          = row_addr(!back_select_r, emit_row_r);
    pix              = '0;

    if (cfg_wr_en) begin
      row_period_nxt = cfg_wr_data;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (opcode_t'(in_opcode))
            OP_DRAW, OP_STORE: begin
              if (in_bounds && (opcode_t'(in_opcode) == OP_STORE ||
                                in_pixel_color != 8'd0)) begin
                mem_we = 1'b1;
                // a row that is not valid yet is written whole, rest black
                for (int c = 0; c < COLUMNS; c++) begin
                  wmask[c] = !row_valid_r[waddr] || (px_col == CW'(c));
                  wdata[c] = (px_col == CW'(c)) ? in_pixel_color[2:0] : 3'd0;
                end
              end
            end
            OP_CLEAR: clear_back = 1'b1;
            OP_REFRESH: begin
              swap_pending_nxt = 1'b1;
              copy_pending_nxt = in_copy_on_swap;
            end
            OP_TICK: begin
              if (cd_dec == 16'd0) begin
                countdown_nxt = row_period_r;
                emit_row_nxt  = scan_row_r;
                scan_row_nxt  = (scan_row_r == RW'(ROWS - 1)) ? '0 : scan_row_r + RW'(1);
                state_nxt     = S_READ;
                if (scan_row_r == '0 && swap_pending_r) begin
                  back_select_nxt  = !back_select_r;
                  swap_pending_nxt = 1'b0;
                  copy_pending_nxt = 1'b0;
                  if (copy_pending_r) begin
                    cp_cnt_nxt = '0;
                    state_nxt  = S_COPY;
                  end
                end
              end else begin
                countdown_nxt = cd_dec;
              end
            end
            default: ;
          endcase
        end
      end
      S_COPY: begin
        // read front row k while writing back row k-1
        if (cp_cnt_r < CNT_W'(ROWS)) begin
          rd_en   = 1'b1;
          rd_addr = row_addr(!back_select_r, cp_cnt_r[RW-1:0]);
        end
        if (cp_cnt_r != '0) begin
          mem_we    = 1'b1;
          waddr     = row_addr(back_select_r, cp_prev[RW-1:0]);
          wmask     = '1;
          wdata     = rd_data_r;
          valid_val = rd_ok_r;
        end
        if (cp_cnt_r == CNT_W'(ROWS)) begin
          state_nxt = S_READ;
        end else begin
          cp_cnt_nxt = cp_cnt_r + CNT_W'(1);
        end
      end
      S_READ: begin
        rd_en     = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_row_nxt   = 4'(emit_row_r);
          out_red_nxt   = '0;
          out_green_nxt = '0;
          out_blue_nxt  = '0;
          for (int c = 0; c < COLUMNS; c++) begin
            pix = rd_ok_r ? rd_data_r[c] : 3'd0;
            out_red_nxt[c]   = |(pix & RED_BIT);
            out_green_nxt[c] = |(pix & GREEN_BIT);
            out_blue_nxt[c]  = |(pix & BLUE_BIT);
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      row_period_r   <= ROW_PERIOD_RESET;
      countdown_r    <= '0;
      scan_row_r     <= '0;
      emit_row_r     <= '0;
      back_select_r  <= 1'b0;
      swap_pending_r <= 1'b0;
      copy_pending_r <= 1'b0;
      cp_cnt_r       <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      row_period_r   <= row_period_nxt;
      countdown_r    <= countdown_nxt;
      scan_row_r     <= scan_row_nxt;
      emit_row_r     <= emit_row_nxt;
      back_select_r  <= back_select_nxt;
      swap_pending_r <= swap_pending_nxt;
      copy_pending_r <= copy_pending_nxt;
      cp_cnt_r       <= cp_cnt_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_row_r   <= out_row_nxt;
    out_red_r   <= out_red_nxt;
    out_green_r <= out_green_nxt;
    out_blue_r  <= out_blue_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
    end else begin
      if (clear_back) begin
        for (int i = 0; i < DEPTH; i++) begin
          if ((i >= ROWS) == back_select_r) begin
            row_valid_r[i] <= 1'b0;
          end
        end
      end
      if (mem_we) begin
        row_valid_r[waddr] <= valid_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      for (int c = 0; c < COLUMNS; c++) begin
        if (wmask[c]) begin
          frame_mem[waddr][c] <= wdata[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= frame_mem[rd_addr];
      rd_ok_r   <= row_valid_r[rd_addr];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_row_index     = out_row_r;
  assign out_red_columns   = out_red_r;
  assign out_green_columns = out_green_r;
  assign out_blue_columns  = out_blue_r;

  // copy only runs right after a swap at row 0
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (emit_row_r == '0 && !swap_pending_r && !copy_pending_r))
    else $error("copy sweep outside a row 0 swap");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COPY) |-> (cp_cnt_r <= CNT_W'(ROWS)))
    else $error("copy counter overrun");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> (state_r == S_EMIT))
    else $error("scan read not followed by emit");

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && (!out_valid_r || out_ready)) |=>
      (out_valid_r && state_r == S_IDLE))
    else $error("scan word not loaded");

endmodule
